>>> rtl/pcc_pkg.sv
// Shared types, constants and the gamma table builder for the pixel color correction block.
package pcc_pkg;

    localparam int CHAN_W           = 8;
    localparam int SAT_W            = 9;
    localparam int BRIGHT_W         = 12;
    localparam int CFG_DATA_W       = 12;
    localparam int CFG_INDEX_W      = 1;

    // Gamma table addressing: the channel level carries GAMMA_FRAC_BITS fraction bits.
    localparam int GAMMA_INDEX_BITS = 10;
    localparam int GAMMA_FRAC_BITS  = GAMMA_INDEX_BITS - 8;
    localparam int GAMMA_LIMIT      = 255 * (1 << GAMMA_FRAC_BITS);
    localparam int GAMMA_DEPTH      = GAMMA_LIMIT + 1;
    localparam int IDX_W            = GAMMA_INDEX_BITS;

    // Blend result is in levels with 12 fraction bits.
    localparam int V_W              = 24;
    localparam int IDX_SHIFT        = 12 - GAMMA_FRAC_BITS;

    // Luma in levels with 4 fraction bits, at most 16 * 765 / 3 = 4080.
    localparam int SUM_W            = 10;
    localparam int LUMA_X_W         = SUM_W + 4;
    localparam int LUMA_W           = 12;
    localparam int DIFF_W           = 13;
    // floor(x / 3) = (x * 43691) >> 17, exact for x below 2^17.
    localparam int DIV3_SHIFT       = 17;
    localparam int DIV3_MUL_W       = 17;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = DIV3_MUL_W'(((1 << DIV3_SHIFT) + 2) / 3);
    localparam int DIV3_PROD_W      = LUMA_X_W + DIV3_MUL_W;

    localparam logic [SAT_W-1:0]    SATURATION_RESET = SAT_W'(243);
    localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RESET = BRIGHT_W'(204);
    localparam logic [CHAN_W-1:0]   ALPHA_OPAQUE     = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SATURATION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 1'd1;

    typedef struct packed {
        logic              lit;
        logic [LUMA_W-1:0] luma;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_luma_stage;

    typedef logic [CHAN_W-1:0] t_gamma_rom [GAMMA_DEPTH];

    // Entry i is the largest y with y^8 * 2^(5F) <= 255^3 * i^5.
    function automatic t_gamma_rom gamma_rom_init();
        t_gamma_rom rom;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [7:0]   y;
        logic [7:0]   cand;
        for (int i = 0; i < GAMMA_DEPTH; i++) begin
            rhs = 128'(255 * 255 * 255);
            for (int k = 0; k < 5; k++) begin
                rhs = rhs * 128'(i);
            end
            y = 8'd0;
            for (int b = 7; b >= 0; b--) begin
                cand = y | (8'd1 << b);
                lhs  = 128'd1;
                for (int k = 0; k < 8; k++) begin
                    lhs = lhs * 128'(cand);
                end
                lhs = lhs << (5 * GAMMA_FRAC_BITS);
                if (lhs <= rhs) begin
                    y = cand;
                end
            end
            rom[i] = y;
        end
        return rom;
    endfunction

endpackage

>>> rtl/pcc_luma.sv
// Luma stage: channel sum, luma as one third of the sum, and the black pixel flag.
module pcc_luma (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [pcc_pkg::CHAN_W-1:0]   i_red,
    input  logic [pcc_pkg::CHAN_W-1:0]   i_green,
    input  logic [pcc_pkg::CHAN_W-1:0]   i_blue,
    output pcc_pkg::t_luma_stage         o_stage
);

    logic [pcc_pkg::SUM_W-1:0]       w_sum;
    logic [pcc_pkg::LUMA_X_W-1:0]    w_sum_x16;
    logic [pcc_pkg::DIV3_PROD_W-1:0] w_prod;
    pcc_pkg::t_luma_stage            n_stage;
    pcc_pkg::t_luma_stage            r_stage;

    always_comb begin
        w_sum     = pcc_pkg::SUM_W'(i_red) + pcc_pkg::SUM_W'(i_green)
                  + pcc_pkg::SUM_W'(i_blue);
        w_sum_x16 = {w_sum, 4'b0000};
        // Division by three as a multiplication by the rounded-up reciprocal.
        w_prod    = pcc_pkg::DIV3_PROD_W'(w_sum_x16) * pcc_pkg::DIV3_PROD_W'(pcc_pkg::DIV3_MUL);
        n_stage.lit   = (w_sum != '0);
        n_stage.luma  = w_prod[pcc_pkg::DIV3_SHIFT +: pcc_pkg::LUMA_W];
        n_stage.red   = i_red;
        n_stage.green = i_green;
        n_stage.blue  = i_blue;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/pcc_chan.sv
// Channel stage: saturation blend toward luma, brightness offset and gamma table index.
module pcc_chan (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [pcc_pkg::CHAN_W-1:0]     i_chan,
    input  logic [pcc_pkg::LUMA_W-1:0]     i_luma,
    input  logic                           i_lit,
    input  logic [pcc_pkg::SAT_W-1:0]      i_saturation_q8,
    input  logic [pcc_pkg::BRIGHT_W-1:0]   i_brightness_q4,
    output logic [pcc_pkg::IDX_W-1:0]      o_idx
);

    logic signed [pcc_pkg::DIFF_W-1:0]            w_diff;
    logic signed [pcc_pkg::DIFF_W+pcc_pkg::SAT_W:0] w_prod;
    logic signed [pcc_pkg::V_W-1:0]               w_base;
    logic signed [pcc_pkg::V_W-1:0]               w_blend;
    logic signed [pcc_pkg::V_W-1:0]               w_offs;
    logic signed [pcc_pkg::V_W-1:0]               w_v;
    logic        [pcc_pkg::V_W-2:0]               w_shifted;
    logic        [pcc_pkg::IDX_W-1:0]             n_idx;
    logic        [pcc_pkg::IDX_W-1:0]             r_idx;

    always_comb begin
        w_diff  = $signed({1'b0, i_chan, 4'b0000}) - $signed({1'b0, i_luma});
        w_prod  = $signed({1'b0, i_saturation_q8}) * w_diff;
        w_base  = $signed({4'b0000, i_luma, 8'h00});
        w_blend = pcc_pkg::V_W'(w_prod);
        w_offs  = i_lit ? $signed({4'b0000, i_brightness_q4, 8'h00}) : '0;
        w_v     = w_base + w_blend + w_offs;
        w_shifted = w_v[pcc_pkg::V_W-2:0] >> pcc_pkg::IDX_SHIFT;
        // A negative level maps to index zero; levels past full scale saturate.
        if (w_v[pcc_pkg::V_W-1]) begin
            n_idx = '0;
        end else if (w_shifted > (pcc_pkg::V_W-1)'(pcc_pkg::GAMMA_LIMIT)) begin
            n_idx = pcc_pkg::IDX_W'(pcc_pkg::GAMMA_LIMIT);
        end else begin
            n_idx = w_shifted[pcc_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

>>> rtl/pcc_gamma_rom.sv
// Gamma 1/1.6 lookup table with a registered read port.
module pcc_gamma_rom (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [pcc_pkg::IDX_W-1:0]   i_addr,
    output logic [pcc_pkg::CHAN_W-1:0]  o_data
);

    localparam pcc_pkg::t_gamma_rom GammaRom = pcc_pkg::gamma_rom_init();

    logic [pcc_pkg::CHAN_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= GammaRom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

>>> rtl/pixel_color_correction_top.sv
// Pixel color correction: saturation, brightness and gamma on one RGB pixel per clock.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one pixel per item as red,
//   green and blue. Output channel (o_out_valid / i_out_ready) carries the
//   corrected red, green and blue with alpha fixed at 255.
//   The datapath is four register stages: input register, luma, blend and
//   table index, and the gamma table read whose registered data is the result.
//   Throughput is one item per clock while the output is not stalled; every stage
//   is fully pipelined and the gamma table is one read per channel per cycle.
//   When the receiver stalls, stages fill up behind the held result and
//   o_in_ready drops only once all four stages hold an item.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data), to be
//   written only while no item is in flight; the block does not enforce this.
//   Unknown indexes are ignored. Synchronous active-low reset empties the
//   pipeline and restores saturation to 243 and brightness to 204.
module pixel_color_correction_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pcc_pkg::CHAN_W-1:0]        i_red_in,
    input  logic [pcc_pkg::CHAN_W-1:0]        i_green_in,
    input  logic [pcc_pkg::CHAN_W-1:0]        i_blue_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pcc_pkg::CHAN_W-1:0]        o_red_out,
    output logic [pcc_pkg::CHAN_W-1:0]        o_green_out,
    output logic [pcc_pkg::CHAN_W-1:0]        o_blue_out,
    output logic [pcc_pkg::CHAN_W-1:0]        o_alpha_out
);

    logic [pcc_pkg::SAT_W-1:0]    r_saturation_q8;
    logic [pcc_pkg::BRIGHT_W-1:0] r_brightness_q4;

    logic                         r_v0;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_v3;
    logic                         w_rdy0;
    logic                         w_rdy1;
    logic                         w_rdy2;
    logic                         w_rdy3;
    logic                         w_en0;
    logic                         w_en1;
    logic                         w_en2;
    logic                         w_en3;

    logic [pcc_pkg::CHAN_W-1:0]   r_red;
    logic [pcc_pkg::CHAN_W-1:0]   r_green;
    logic [pcc_pkg::CHAN_W-1:0]   r_blue;

    pcc_pkg::t_luma_stage         w_luma;
    logic [pcc_pkg::IDX_W-1:0]    w_idx_red;
    logic [pcc_pkg::IDX_W-1:0]    w_idx_green;
    logic [pcc_pkg::IDX_W-1:0]    w_idx_blue;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saturation_q8 <= pcc_pkg::SATURATION_RESET;
            r_brightness_q4 <= pcc_pkg::BRIGHTNESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcc_pkg::REG_SATURATION: r_saturation_q8 <= i_cfg_data[pcc_pkg::SAT_W-1:0];
                pcc_pkg::REG_BRIGHTNESS: r_brightness_q4 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        w_rdy3 = !r_v3 || i_out_ready;
        w_rdy2 = !r_v2 || w_rdy3;
        w_rdy1 = !r_v1 || w_rdy2;
        w_rdy0 = !r_v0 || w_rdy1;
        w_en0  = w_rdy0 && i_in_valid;
        w_en1  = w_rdy1 && r_v0;
        w_en2  = w_rdy2 && r_v1;
        w_en3  = w_rdy3 && r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_in_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0) begin
            r_red   <= i_red_in;
            r_green <= i_green_in;
            r_blue  <= i_blue_in;
        end
    end

    pcc_luma u_luma (
        .i_clk   (i_clk),
        .i_en    (w_en1),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_stage (w_luma)
    );

    pcc_chan u_chan_red (
        .i_clk           (i_clk),
        .i_en            (w_en2),
        .i_chan          (w_luma.red),
        .i_luma          (w_luma.luma),
        .i_lit           (w_luma.lit),
        .i_saturation_q8 (r_saturation_q8),
        .i_brightness_q4 (r_brightness_q4),
        .o_idx           (w_idx_red)
    );

    pcc_chan u_chan_green (
        .i_clk           (i_clk),
        .i_en            (w_en2),
        .i_chan          (w_luma.green),
        .i_luma          (w_luma.luma),
        .i_lit           (w_luma.lit),
        .i_saturation_q8 (r_saturation_q8),
        .i_brightness_q4 (r_brightness_q4),
        .o_idx           (w_idx_green)
    );

    pcc_chan u_chan_blue (
        .i_clk           (i_clk),
        .i_en            (w_en2),
        .i_chan          (w_luma.blue),
        .i_luma          (w_luma.luma),
        .i_lit           (w_luma.lit),
        .i_saturation_q8 (r_saturation_q8),
        .i_brightness_q4 (r_brightness_q4),
        .o_idx           (w_idx_blue)
    );

    pcc_gamma_rom u_gamma_red (
        .i_clk  (i_clk),
        .i_en   (w_en3),
        .i_addr (w_idx_red),
        .o_data (o_red_out)
    );

    pcc_gamma_rom u_gamma_green (
        .i_clk  (i_clk),
        .i_en   (w_en3),
        .i_addr (w_idx_green),
        .o_data (o_green_out)
    );

    pcc_gamma_rom u_gamma_blue (
        .i_clk  (i_clk),
        .i_en   (w_en3),
        .i_addr (w_idx_blue),
        .o_data (o_blue_out)
    );

    assign o_in_ready  = w_rdy0;
    assign o_out_valid = r_v3;
    assign o_alpha_out = pcc_pkg::ALPHA_OPAQUE;

    // Input back-pressure only happens with every stage occupied.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v0 && r_v1 && r_v2 && r_v3))
        else $error("input blocked while a pipeline stage is empty");

    // A black pixel gets no brightness and must index the zero entry of the table.
    a_black_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en2 && !w_luma.lit) |=>
        (w_idx_red == '0 && w_idx_green == '0 && w_idx_blue == '0))
        else $error("black pixel produced a nonzero gamma index");

    // Reset leaves no result on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

>>> verif/pixel_correction_checker.sv
// Checker for the pixel color correction block: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module pixel_correction_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [pcc_pkg::CHAN_W-1:0]      i_red_in,
    input  logic [pcc_pkg::CHAN_W-1:0]      i_green_in,
    input  logic [pcc_pkg::CHAN_W-1:0]      i_blue_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [pcc_pkg::CHAN_W-1:0]      i_red_out,
    input  logic [pcc_pkg::CHAN_W-1:0]      i_green_out,
    input  logic [pcc_pkg::CHAN_W-1:0]      i_blue_out,
    input  logic [pcc_pkg::CHAN_W-1:0]      i_alpha_out,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);
    import pcc_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } corrected_pixel_t;

    logic [CHAN_W-1:0]   gamma_curve [GAMMA_DEPTH];
    logic [SAT_W-1:0]    saturation_q8 = SATURATION_RESET;
    logic [BRIGHT_W-1:0] brightness_q4 = BRIGHTNESS_RESET;
    corrected_pixel_t    awaited_pixels [$];
    int                  fail_count = 0;
    int                  checked = 0;

    function automatic logic [127:0] power_of(logic [127:0] base, int exponent);
        logic [127:0] acc;
        acc = 128'd1;
        for (int k = 0; k < exponent; k++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // The curve never falls, so each entry starts its search from the previous one.
    // An entry is the largest level y with y^8 * 2^(5F) <= 255^3 * index^5.
    initial begin : build_gamma_curve
        logic [127:0] bound;
        int           level;
        level = 0;
        for (int i = 0; i < GAMMA_DEPTH; i++) begin
            bound = 128'(16581375) * power_of(128'(i), 5);
            while (level < 255 &&
                   (power_of(128'(level + 1), 8) << (5 * GAMMA_FRAC_BITS)) <= bound) begin
                level++;
            end
            gamma_curve[i] = CHAN_W'(level);
        end
    end

    function automatic logic [CHAN_W-1:0] corrected_level(int level, int luma, bit lit);
        int blend;
        int index;
        blend = 256 * luma + int'(saturation_q8) * (16 * level - luma);
        if (lit) begin
            blend += 256 * int'(brightness_q4);
        end
        if (blend < 0) begin
            blend = 0;
        end
        index = blend >>> IDX_SHIFT;
        if (index > GAMMA_LIMIT) begin
            index = GAMMA_LIMIT;
        end
        return gamma_curve[index];
    endfunction

    function automatic corrected_pixel_t corrected_pixel(logic [CHAN_W-1:0] r,
                                                         logic [CHAN_W-1:0] g,
                                                         logic [CHAN_W-1:0] b);
        int               sum;
        int               luma;
        bit               lit;
        corrected_pixel_t px;
        sum  = int'(r) + int'(g) + int'(b);
        luma = (16 * sum) / 3;
        lit  = (sum != 0);
        px.red   = corrected_level(int'(r), luma, lit);
        px.green = corrected_level(int'(g), luma, lit);
        px.blue  = corrected_level(int'(b), luma, lit);
        px.alpha = ALPHA_OPAQUE;
        return px;
    endfunction

    task automatic compare_channel(string name, logic [CHAN_W-1:0] want,
                                   logic [CHAN_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        corrected_pixel_t want;
        if (!i_rst_n) begin
            saturation_q8 = SATURATION_RESET;
            brightness_q4 = BRIGHTNESS_RESET;
            awaited_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SATURATION: saturation_q8 = SAT_W'(i_cfg_data);
                    REG_BRIGHTNESS: brightness_q4 = BRIGHT_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_pixels.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no pixel awaited, expected none, actual %h",
                             $time, {i_red_out, i_green_out, i_blue_out, i_alpha_out});
                end else begin
                    want = awaited_pixels.pop_front();
                    checked++;
                    compare_channel("red", want.red, i_red_out);
                    compare_channel("green", want.green, i_green_out);
                    compare_channel("blue", want.blue, i_blue_out);
                    compare_channel("alpha", want.alpha, i_alpha_out);
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_pixels.push_back(corrected_pixel(i_red_in, i_green_in, i_blue_in));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_pixels.size();
        o_checked    <= checked;
    end

endmodule

>>> verif/tb_pixel_color_correction_top.sv
// Testbench top for the pixel color correction block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_pixel_color_correction_top;
    import pcc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 93;
    localparam int DRAIN_CYCLES    = 8;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [CHAN_W-1:0]      red_in;
    logic [CHAN_W-1:0]      green_in;
    logic [CHAN_W-1:0]      blue_in;
    logic                   out_valid;
    logic                   out_ready;
    logic [CHAN_W-1:0]      red_out;
    logic [CHAN_W-1:0]      green_out;
    logic [CHAN_W-1:0]      blue_out;
    logic [CHAN_W-1:0]      alpha_out;

    int fail_count;
    int pending;
    int checked;
    int sent = 0;
    int settings = 1;
    int quiet_cycles = 0;
    bit sender_eager = 1'b0;
    bit receiver_eager = 1'b0;

    logic [23:0] directed_pixels [8] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
        24'h0000FF, 24'h010000, 24'h000001, 24'hFE01FE
    };

    always #4 clk = ~clk;

    pixel_color_correction_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_red_in    (red_in),
        .i_green_in  (green_in),
        .i_blue_in   (blue_in),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_red_out   (red_out),
        .o_green_out (green_out),
        .o_blue_out  (blue_out),
        .o_alpha_out (alpha_out)
    );

    pixel_correction_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_red_in     (red_in),
        .i_green_in   (green_in),
        .i_blue_in    (blue_in),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_red_out    (red_out),
        .i_green_out  (green_out),
        .i_blue_out   (blue_out),
        .i_alpha_out  (alpha_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: %0d cycles without an accepted item", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Half of the pixels have unrelated channels; the rest are near-gray, corner-valued,
    // single-channel, or black or white pixels.
    function automatic logic [23:0] random_pixel();
        logic [7:0] ch [3];
        int         base;
        int         level;
        case ($urandom_range(0, 9))
            5, 6: begin
                base = $urandom_range(0, 255);
                for (int i = 0; i < 3; i++) begin
                    level = base + int'($urandom_range(0, 8)) - 4;
                    if (level < 0) level = 0;
                    if (level > 255) level = 255;
                    ch[i] = 8'(level);
                end
            end
            7: begin
                for (int i = 0; i < 3; i++) begin
                    ch[i] = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                                 : 8'($urandom_range(0, 1));
                end
            end
            8: begin
                for (int i = 0; i < 3; i++) ch[i] = 8'd0;
                ch[$urandom_range(0, 2)] = 8'($urandom);
            end
            9: begin
                base = $urandom_range(0, 1) ? 255 : 0;
                for (int i = 0; i < 3; i++) ch[i] = 8'(base);
            end
            default: begin
                for (int i = 0; i < 3; i++) ch[i] = 8'($urandom);
            end
        endcase
        return {ch[0], ch[1], ch[2]};
    endfunction

    task automatic send_pixel(logic [23:0] px);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 31) == 0) sender_eager = !sender_eager;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        red_in   <= px[23:16];
        green_in <= px[15:8];
        blue_in  <= px[7:0];
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // Registers change only once every item in flight has come out.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] saturation,
                                logic [CFG_DATA_W-1:0] brightness);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SATURATION;
        cfg_data  <= saturation;
        @(posedge clk);
        cfg_index <= REG_BRIGHTNESS;
        cfg_data  <= brightness;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    initial begin : result_receiver
        int stall;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = receiver_eager ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 31) == 0) receiver_eager = !receiver_eager;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] sat_data;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SATURATION;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        red_in    <= '0;
        green_in  <= '0;
        blue_in   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pixels under the reset setting, an extrapolating weight that
        // drives channels negative, and full brightness that saturates the table.
        for (int pass = 0; pass < 3; pass++) begin
            if (pass == 1) write_config(12'd511, 12'd0);
            if (pass == 2) write_config(12'd0, 12'd4095);
            for (int i = 0; i < 8; i++) send_pixel(directed_pixels[i]);
            settle();
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: write_config(12'd256, 12'd0);
                1: write_config(12'hFFF, 12'd4095);
                2: write_config(12'd0, 12'd0);
                3: write_config(12'd256, 12'd4095);
                default: begin
                    sat_data = $urandom_range(0, 1) ? 12'($urandom_range(0, 256))
                                                    : 12'($urandom_range(0, 4095));
                    write_config(sat_data, 12'($urandom_range(0, 4095)));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_pixel(random_pixel());
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d pixels under %0d register settings; %0d results compared.",
                 sent, settings, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
